// ===== rtl/abkt_pkg.sv =====
package abkt_pkg;

    localparam int KEY_W    = 32;
    localparam int RANK_W   = 7;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic ORDER_PRE   = 1'b0;
    localparam logic ORDER_LEVEL = 1'b1;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_LEFT,
        IDX_RIGHT,
        IDX_PARENT
    } idx_op_t;

    typedef struct packed {
        logic    load_item;
        idx_op_t idx_op;
        logic    mem_write;
        logic    wr_valid;
        logic    count_inc;
        logic    found_load;
        logic    res_load;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic slot_valid;
        logic less;
        logic count_hit;
        logic idx_zero;
        logic idx_odd;
        logic idx_last;
        logic order;
        logic rank_zero;
    } stat_t;

endpackage

// ===== rtl/abkt_dpath.sv =====
module abkt_dpath
    import abkt_pkg::*;
#(
    parameter int NODE_SLOTS = 127
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic signed [KEY_W-1:0]  key,
    input  logic                     order,
    input  logic [RANK_W-1:0]        rank,
    output stat_t                    stat,
    output logic signed [KEY_W-1:0]  value
);

    localparam int IW   = $clog2(NODE_SLOTS);
    localparam int CW   = $clog2(2 * NODE_SLOTS + 1);
    localparam int CNTW = $clog2(NODE_SLOTS + 1);
    localparam int CMPW = ((CNTW > RANK_W) ? CNTW : RANK_W) + 1;

    // word layout: valid bit above the key
    logic [KEY_W:0]          slot_mem [NODE_SLOTS];
    logic [KEY_W:0]          rd_reg;

    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           idx_next;
    logic [CNTW-1:0]         count_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    order_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic signed [KEY_W-1:0] found_reg;
    logic signed [KEY_W-1:0] value_reg;
    logic                    in_range;
    logic signed [KEY_W-1:0] rd_key;

    assign in_range = idx_reg < CW'(NODE_SLOTS);
    assign rd_key   = rd_reg[KEY_W-1:0];

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:   idx_next = idx_reg;
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + CW'(1);
            IDX_LEFT:   idx_next = CW'({idx_reg, 1'b0}) + CW'(1);
            IDX_RIGHT:  idx_next = CW'({idx_reg, 1'b0}) + CW'(2);
            IDX_PARENT: idx_next = CW'(idx_reg >> 1) - CW'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load_item)
                count_reg <= '0;
            else if (cmd.count_inc)
                count_reg <= count_reg + CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            key_reg   <= key;
            order_reg <= order;
            rank_reg  <= rank;
            found_reg <= '0;
        end
        else if (cmd.found_load)
            found_reg <= rd_key;
        if (cmd.res_load)
            value_reg <= found_reg;
    end

    // single port memory, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            slot_mem[idx_reg[IW-1:0]] <= {cmd.wr_valid, key_reg};
        if (in_range)
            rd_reg <= slot_mem[idx_reg[IW-1:0]];
    end

    assign stat.in_range   = in_range;
    assign stat.slot_valid = in_range && rd_reg[KEY_W];
    assign stat.less       = key_reg < rd_key;
    assign stat.count_hit  = (CMPW'(count_reg) + CMPW'(1)) == CMPW'(rank_reg);
    assign stat.idx_zero   = idx_reg == '0;
    assign stat.idx_odd    = idx_reg[0];
    assign stat.idx_last   = idx_reg == CW'(NODE_SLOTS - 1);
    assign stat.order      = order_reg;
    assign stat.rank_zero  = rank_reg == '0;

    assign value = value_reg;

endmodule

// ===== rtl/abkt_ctrl.sv =====
module abkt_ctrl
    import abkt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FUNC_W-1:0]   func,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    input  stat_t               stat,
    output cmd_t                cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_INS_RD,
        ST_INS_CHK,
        ST_QRY,
        ST_LVL_RD,
        ST_LVL_CHK,
        ST_PRE_RD,
        ST_PRE_CHK,
        ST_PRE_UP,
        ST_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STATUS_W-1:0] pend_reg;
    logic [STATUS_W-1:0] pend_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic                accept;
    logic                out_free;

    assign in_stall = state_reg != ST_IDLE;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        cmd             = '0;
        cmd.idx_op      = IDX_HOLD;

        case (state_reg)
            ST_INIT, ST_CLR:
            begin
                cmd.mem_write = 1'b1;
                cmd.wr_valid  = 1'b0;
                if (stat.idx_last)
                begin
                    cmd.idx_op = IDX_ZERO;
                    pend_next  = STATUS_OK;
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                    cmd.idx_op = IDX_INC;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_op    = IDX_ZERO;
                    pend_next     = STATUS_OK;
                    case (func)
                        FUNC_CLEAR:  state_next = ST_CLR;
                        FUNC_INSERT: state_next = ST_INS_RD;
                        FUNC_QUERY:  state_next = ST_QRY;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS_RD:
                state_next = ST_INS_CHK;
            ST_INS_CHK:
            begin
                if (!stat.in_range)
                begin
                    pend_next  = STATUS_OVERFLOW;
                    state_next = ST_DONE;
                end
                else if (!stat.slot_valid)
                begin
                    cmd.mem_write = 1'b1;
                    cmd.wr_valid  = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.idx_op = stat.less ? IDX_LEFT : IDX_RIGHT;
                    state_next = ST_INS_RD;
                end
            end
            ST_QRY:
            begin
                if (stat.rank_zero)
                begin
                    pend_next  = STATUS_NOTFOUND;
                    state_next = ST_DONE;
                end
                else if (stat.order == ORDER_LEVEL)
                    state_next = ST_LVL_RD;
                else
                    state_next = ST_PRE_RD;
            end
            ST_LVL_RD:
                state_next = ST_LVL_CHK;
            ST_LVL_CHK:
            begin
                if (!stat.in_range)
                begin
                    pend_next  = STATUS_NOTFOUND;
                    state_next = ST_DONE;
                end
                else if (stat.slot_valid && stat.count_hit)
                begin
                    cmd.found_load = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.count_inc = stat.slot_valid;
                    cmd.idx_op    = IDX_INC;
                    state_next    = ST_LVL_RD;
                end
            end
            ST_PRE_RD:
                state_next = ST_PRE_CHK;
            ST_PRE_CHK, ST_PRE_UP:
            begin
                if (state_reg == ST_PRE_CHK && stat.slot_valid)
                begin
                    if (stat.count_hit)
                    begin
                        cmd.found_load = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        cmd.count_inc = 1'b1;
                        cmd.idx_op    = IDX_LEFT;
                        state_next    = ST_PRE_RD;
                    end
                end
                // subtree at idx is finished: try right sibling, climb, or end at the root
                else if (stat.idx_odd)
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = ST_PRE_RD;
                end
                else if (stat.idx_zero)
                begin
                    pend_next  = STATUS_NOTFOUND;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_PARENT;
                    state_next = ST_PRE_UP;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.res_load    = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            pend_reg       <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;

endmodule

// ===== rtl/array_bst_insert_kth_traversal.sv =====
// Binary search tree in heap layout (children of slot i at 2i+1 and 2i+2), one
// item at a time. Keys and valid bits share one single-port memory with a
// registered read, and every probe of a slot passes a read state and then a
// check state, which sets the pace: an insert probes one slot per tree level
// walked, a query first picks its walk and then, in level order, scans slots
// up to the hit or the end of the array, or in preorder probes slots and
// passes a climb state per level on the way back up, and a clear writes one
// slot per cycle. After reset the block first runs a clearing pass with stall
// held high. Each result passes through the output register; the next item
// may be taken while that result waits.
module array_bst_insert_kth_traversal
    import abkt_pkg::*;
#(
    parameter int NODE_SLOTS = 127
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [FUNC_W-1:0]       func,
    input  logic signed [KEY_W-1:0] key,
    input  logic                    order,
    input  logic [RANK_W-1:0]       rank,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [KEY_W-1:0] value,
    output logic [STATUS_W-1:0]     status
);

    cmd_t  cmd;
    stat_t stat;

    abkt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .stat      (stat),
        .cmd       (cmd)
    );

    abkt_dpath #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_dpath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .key   (key),
        .order (order),
        .rank  (rank),
        .stat  (stat),
        .value (value)
    );

endmodule
